// ----- sv/apd_pkg.sv -----
// Package for the asset pack deframer: byte tags, status codes, parser
// state and result records shared by the step logic, top level and checker.
// No dependencies.
package apd_pkg;

	typedef enum logic [2:0] {
		KIND_HEADER,
		KIND_KEYLEN,
		KIND_KEY,
		KIND_DATALEN,
		KIND_DATA,
		KIND_IGNORED
	} kind_t;

	typedef enum logic [2:0] {
		ST_BUSY,
		ST_OK,
		ST_MAGIC,
		ST_SHORT,
		ST_OVERRUN
	} status_t;

	localparam logic [31:0] HEADER_BYTES = 32'd12;
	localparam logic [3:0]  HEADER_LAST  = 4'd11;
	localparam logic [3:0]  COUNT_FIRST  = 4'd8;
	localparam logic [3:0]  MAGIC_BYTES  = 4'd4;
	localparam logic [31:0] LEN_BYTES    = 32'd4;

	typedef struct packed {
		kind_t       phase;
		logic [32:0] byte_offset;
		logic [31:0] field_left;
		logic [31:0] length_shift;
		logic [31:0] entries_left;
		logic [31:0] entry_index;
		status_t     parse_status;
	} apd_state_t;

	localparam apd_state_t STATE_RESET = '{
		phase:        KIND_HEADER,
		byte_offset:  33'd0,
		field_left:   32'd0,
		length_shift: 32'd0,
		entries_left: 32'd0,
		entry_index:  32'd0,
		parse_status: ST_BUSY
	};

	typedef struct packed {
		logic [7:0]  out_byte;
		kind_t       kind;
		logic [31:0] entry;
		logic        fend;
		status_t     status;
	} apd_result_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] m;
		case (idx)
			2'd0: m = 8'h4E; // 'N'
			2'd1: m = 8'h32; // '2'
			2'd2: m = 8'h44; // 'D'
			default: m = 8'h41; // 'A'
		endcase
		return m;
	endfunction

endpackage

// ----- sv/apd_step.sv -----
// Combinational parse step of the asset pack deframer: one byte against the
// current parser state gives the next state and the tagged result.
// Depends on apd_pkg.
module apd_step (
	input  apd_pkg::apd_state_t  st,
	input  logic [31:0]          pak_size,
	input  logic [7:0]           data_byte,
	input  logic                 first_byte,
	output apd_pkg::apd_state_t  nxt,
	output apd_pkg::apd_result_t res
);
	import apd_pkg::*;

	// Open a length field, or fail short when four bytes no longer fit.
	function automatic apd_state_t open_length(input apd_state_t s, input kind_t k,
			input logic room);
		apd_state_t r;
		r = s;
		if (!room) begin
			r.parse_status = ST_SHORT;
			r.phase = KIND_IGNORED;
		end else begin
			r.phase = k;
			r.field_left = LEN_BYTES;
			r.length_shift = 32'd0;
		end
		return r;
	endfunction

	function automatic apd_state_t close_entry(input apd_state_t s, input logic room);
		apd_state_t r;
		r = s;
		r.entry_index = s.entry_index + 32'd1;
		r.entries_left = s.entries_left - 32'd1;
		if (r.entries_left == 32'd0) begin
			r.parse_status = ST_OK;
			r.phase = KIND_IGNORED;
		end else begin
			r = open_length(r, KIND_KEYLEN, room);
		end
		return r;
	endfunction

	apd_state_t  cur;
	logic [3:0]  hoff;
	logic [1:0]  pos;
	logic [31:0] byte_ext;
	logic [31:0] fl_dec;
	logic [31:0] len;
	logic        room;
	logic        overrun;
	logic        fend;
	kind_t       kind;

	always_comb begin
		cur = first_byte ? STATE_RESET : st;
		nxt = cur;
		kind = cur.phase;
		fend = 1'b0;
		hoff = cur.byte_offset[3:0];
		pos = 2'd0 - cur.field_left[1:0];
		byte_ext = {24'd0, data_byte};
		fl_dec = cur.field_left - 32'd1;
		// offset+1+4 <= pak_size
		room = ({1'b0, cur.byte_offset} + {2'b00, LEN_BYTES}) < {2'b00, pak_size};
		len = cur.length_shift | (byte_ext << {pos, 3'b000});
		// offset+1+len > pak_size
		overrun = ({1'b0, cur.byte_offset} + {2'b00, len}) >= {2'b00, pak_size};

		case (cur.phase)
			KIND_HEADER: begin
				if (hoff == 4'd0 && pak_size < HEADER_BYTES) begin
					nxt.parse_status = ST_SHORT;
					nxt.phase = KIND_IGNORED;
				end else if (hoff < MAGIC_BYTES && data_byte != magic_byte(hoff[1:0])) begin
					nxt.parse_status = ST_MAGIC;
					nxt.phase = KIND_IGNORED;
				end else begin
					if (hoff >= COUNT_FIRST)
						nxt.length_shift = cur.length_shift | (byte_ext << {hoff[1:0], 3'b000});
					nxt.byte_offset = cur.byte_offset + 33'd1;
					if (hoff >= HEADER_LAST) begin
						fend = 1'b1;
						nxt.entries_left = nxt.length_shift;
						nxt.entry_index = 32'd0;
						if (nxt.length_shift == 32'd0) begin
							nxt.parse_status = ST_OK;
							nxt.phase = KIND_IGNORED;
						end else begin
							nxt = open_length(nxt, KIND_KEYLEN, room);
						end
					end
				end
			end
			KIND_KEYLEN, KIND_DATALEN: begin
				nxt.length_shift = len;
				nxt.byte_offset = cur.byte_offset + 33'd1;
				nxt.field_left = fl_dec;
				if (fl_dec == 32'd0) begin
					fend = 1'b1;
					if (overrun) begin
						nxt.parse_status = ST_OVERRUN;
						nxt.phase = KIND_IGNORED;
					end else if (len == 32'd0) begin
						if (cur.phase == KIND_KEYLEN)
							nxt = open_length(nxt, KIND_DATALEN, room);
						else
							nxt = close_entry(nxt, room);
					end else begin
						nxt.field_left = len;
						nxt.phase = (cur.phase == KIND_KEYLEN) ? KIND_KEY : KIND_DATA;
					end
				end
			end
			KIND_KEY, KIND_DATA: begin
				nxt.byte_offset = cur.byte_offset + 33'd1;
				nxt.field_left = fl_dec;
				if (fl_dec == 32'd0) begin
					fend = 1'b1;
					if (cur.phase == KIND_KEY)
						nxt = open_length(nxt, KIND_DATALEN, room);
					else
						nxt = close_entry(nxt, room);
				end
			end
			default: begin
				kind = KIND_IGNORED;
			end
		endcase

		res.out_byte = data_byte;
		res.kind = kind;
		res.entry = cur.entry_index;
		// drop the end flag on the byte that raises an error
		res.fend = fend && (nxt.parse_status == ST_BUSY || nxt.parse_status == ST_OK);
		res.status = nxt.parse_status;
	end

endmodule

// ----- sv/asset_pack_deframer_top.sv -----
// Top level of the asset pack deframer: input register, parser state,
// result register and the pak_size configuration register.
// Depends on apd_pkg and apd_step.

// Takes a pack image one byte per transaction and returns one tagged result
// transaction per byte, in order: the byte, its field kind, its entry number,
// an end-of-field flag and the parse status after that byte. Throughput is
// one byte per cycle while out_stall is low. A byte passes two register
// stages (input register, then result register) before its result shows
// at the output, where it stays offered until it is taken. The
// whole parse step for a byte (magic check, little-endian length assembly
// and the 34-bit bound checks against pak_size) happens between the input
// register and the result register, and the parser state updates in the
// same cycle, so consecutive bytes never wait on each other. Assert
// first_byte on byte 0 of each pack to restart parsing; out of reset the
// block is already at the start of a pack. Write pak_size through
// cfg_we/cfg_wdata only while no transaction is in flight. After done or an
// error every byte is tagged ignored until the next first_byte.
module asset_pack_deframer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [2:0]  byte_kind,
	output logic [31:0] entry_number,
	output logic        field_end,
	output logic [2:0]  status
);
	import apd_pkg::*;

	logic [31:0] pak_size_q;
	apd_state_t  st_q;
	apd_state_t  st_nxt;
	apd_result_t res;

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        first_s1;
	logic        valid_s2;
	apd_result_t res_s2;
	logic        advance;

	// Move the held byte into the result register when that register is
	// empty or being drained this cycle.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	// Hold off the source only while a byte waits in the input register.
	assign in_stall = valid_s1 && !advance;

	apd_step u_step (
		.st         (st_q),
		.pak_size   (pak_size_q),
		.data_byte  (data_s1),
		.first_byte (first_s1),
		.nxt        (st_nxt),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pak_size_q <= 32'd0;
			st_q <= STATE_RESET;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_we)
				pak_size_q <= cfg_wdata;
			// Input register: fill on an accepted transaction, empty on advance.
			if (in_valid && !in_stall)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			// Result register and parser state advance together.
			if (advance) begin
				valid_s2 <= 1'b1;
				st_q <= st_nxt;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			first_s1 <= first_byte;
		end
		if (advance)
			res_s2 <= res;
	end

	assign out_valid    = valid_s2;
	assign out_byte     = res_s2.out_byte;
	assign byte_kind    = res_s2.kind;
	assign entry_number = res_s2.entry;
	assign field_end    = res_s2.fend;
	assign status       = res_s2.status;

endmodule

// ----- sv/apd_checker.sv -----
// Port-level checker for the asset pack deframer and its bind to the top.
// Depends on apd_pkg and asset_pack_deframer_top.
module apd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  byte_kind,
	input logic [31:0] entry_number,
	input logic        field_end,
	input logic [2:0]  status
);
	import apd_pkg::*;

	// A stalled result transaction stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result transaction dropped while stalled");

	// An end of field never coincides with an error status.
	a_fend_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_end |-> (status == ST_BUSY || status == ST_OK))
		else $error("field end flagged with error status");

	// Ignored bytes never end a field.
	a_ignored_fend: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_kind == KIND_IGNORED |-> !field_end)
		else $error("field end on ignored byte");

	// Header bytes belong to entry zero.
	a_header_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_kind == KIND_HEADER |-> entry_number == 32'd0)
		else $error("header byte with nonzero entry number");

	// While busy, the tag is never ignored.
	a_busy_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_BUSY |-> byte_kind != KIND_IGNORED)
		else $error("ignored byte while parser busy");

endmodule

bind asset_pack_deframer_top apd_checker u_apd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.byte_kind    (byte_kind),
	.entry_number (entry_number),
	.field_end    (field_end),
	.status       (status)
);

// ----- verif/testbench.sv -----
// Self-checking testbench for asset_pack_deframer_top: queued pack images,
// a bursty byte driver, a stalling result monitor and an in-line parse predictor.
// Depends on apd_pkg and the asset_pack_deframer_top RTL.
module testbench;
	import apd_pkg::*;

	localparam logic [31:0] HDR_LEN     = 32'd12;
	// "N2DA" with the first character in the low byte
	localparam logic [31:0] PACK_MAGIC  = 32'h4144_324E;
	localparam int          RANDOM_BYTES = 1000;
	localparam int          QUIET_LIMIT  = 4000;
	localparam int          TAIL_CYCLES  = 4;
	localparam int          PRINT_CAP    = 40;

	typedef struct packed {
		logic [7:0] value;
		logic       first;
	} stim_t;

	typedef struct packed {
		logic [7:0]  value;
		kind_t       kind;
		logic [31:0] entry;
		logic        fend;
		status_t     status;
	} deframed_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = 32'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'd0;
	logic        first_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic [2:0]  byte_kind;
	logic [31:0] entry_number;
	logic        field_end;
	logic [2:0]  status;

	// Predicted parser state, updated once per accepted input transaction.
	kind_t       cur_kind = KIND_HEADER;
	logic [32:0] cur_offset = 33'd0;
	logic [31:0] field_remaining = 32'd0;
	logic [31:0] len_accum = 32'd0;
	logic [31:0] entries_remaining = 32'd0;
	logic [31:0] entry_count = 32'd0;
	status_t     cur_status = ST_BUSY;
	logic [31:0] pak_bound = 32'd0;

	stim_t       image_q[$];
	deframed_t   deframed_q[$];
	logic [7:0]  pack_img[$];

	int unsigned accepted_bytes = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned quiet_cycles = 0;
	logic [15:0] stall_pat = 16'h0000;
	logic [5:0]  stall_phase = 6'd0;

	asset_pack_deframer_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.first_byte   (first_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.byte_kind    (byte_kind),
		.entry_number (entry_number),
		.field_end    (field_end),
		.status       (status)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Parse predictor
	// ---------------------------------------------------------------------

	function automatic void restart_parse();
		cur_kind = KIND_HEADER;
		cur_offset = 33'd0;
		field_remaining = 32'd0;
		len_accum = 32'd0;
		entries_remaining = 32'd0;
		entry_count = 32'd0;
		cur_status = ST_BUSY;
	endfunction

	// Any error parks the parser until the next restart.
	function automatic void abort_parse(input status_t code);
		cur_status = code;
		cur_kind = KIND_IGNORED;
	endfunction

	// A 4-byte length field must fit entirely inside the pack.
	function automatic void open_length(input kind_t k);
		if ({31'd0, cur_offset} + 64'd4 > {32'd0, pak_bound}) begin
			abort_parse(ST_SHORT);
		end else begin
			cur_kind = k;
			field_remaining = 32'd4;
			len_accum = 32'd0;
		end
	endfunction

	function automatic void close_entry();
		entry_count = entry_count + 32'd1;
		entries_remaining = entries_remaining - 32'd1;
		if (entries_remaining == 32'd0) begin
			cur_status = ST_OK;
			cur_kind = KIND_IGNORED;
		end else begin
			open_length(KIND_KEYLEN);
		end
	endfunction

	function automatic deframed_t deframe_byte(input logic [7:0] b, input logic restart);
		deframed_t r;
		logic [3:0] off;
		logic [1:0] pos;
		logic fend;
		fend = 1'b0;
		if (restart)
			restart_parse();
		r.kind = cur_kind;
		r.entry = entry_count;
		case (cur_kind)
			KIND_HEADER: begin
				off = cur_offset[3:0];
				if (off == 4'd0 && pak_bound < HDR_LEN) begin
					abort_parse(ST_SHORT);
				end else if (off < 4'd4 && b != PACK_MAGIC[{off[1:0], 3'b000} +: 8]) begin
					abort_parse(ST_MAGIC);
				end else begin
					// header bytes 8..11 carry the entry count, little-endian
					if (off >= 4'd8)
						len_accum = len_accum | ({24'd0, b} << {off[1:0], 3'b000});
					cur_offset = cur_offset + 33'd1;
					if (off >= 4'd11) begin
						fend = 1'b1;
						entries_remaining = len_accum;
						entry_count = 32'd0;
						if (entries_remaining == 32'd0) begin
							cur_status = ST_OK;
							cur_kind = KIND_IGNORED;
						end else begin
							open_length(KIND_KEYLEN);
						end
					end
				end
			end
			KIND_KEYLEN, KIND_DATALEN: begin
				pos = 2'd0 - field_remaining[1:0];
				len_accum = len_accum | ({24'd0, b} << {pos, 3'b000});
				cur_offset = cur_offset + 33'd1;
				field_remaining = field_remaining - 32'd1;
				if (field_remaining == 32'd0) begin
					fend = 1'b1;
					if ({31'd0, cur_offset} + {32'd0, len_accum} > {32'd0, pak_bound}) begin
						fend = 1'b0;
						abort_parse(ST_OVERRUN);
					end else if (len_accum == 32'd0) begin
						// empty key or data: skip straight to what follows
						if (cur_kind == KIND_KEYLEN)
							open_length(KIND_DATALEN);
						else
							close_entry();
					end else begin
						field_remaining = len_accum;
						cur_kind = (cur_kind == KIND_KEYLEN) ? KIND_KEY : KIND_DATA;
					end
				end
			end
			KIND_KEY, KIND_DATA: begin
				cur_offset = cur_offset + 33'd1;
				field_remaining = field_remaining - 32'd1;
				if (field_remaining == 32'd0) begin
					fend = 1'b1;
					if (cur_kind == KIND_KEY)
						open_length(KIND_DATALEN);
					else
						close_entry();
				end
			end
			default: begin
				r.kind = KIND_IGNORED;
			end
		endcase
		// the byte that raises an error never closes a field
		if (cur_status == ST_MAGIC || cur_status == ST_SHORT || cur_status == ST_OVERRUN)
			fend = 1'b0;
		r.value = b;
		r.fend = fend;
		r.status = cur_status;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	task automatic queue_byte(input logic [7:0] v, input logic restart);
		stim_t s;
		s.value = v;
		s.first = restart;
		image_q.push_back(s);
	endtask

	function automatic void add_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			pack_img.push_back(w[8*i +: 8]);
	endfunction

	function automatic void start_header(input logic [31:0] version, input logic [31:0] count);
		pack_img.delete();
		add_word(PACK_MAGIC);
		add_word(version);
		add_word(count);
	endfunction

	// Send pack_img[lo..hi-1]; raise first_byte on the first of them if asked.
	task automatic queue_slice(input int lo, input int hi, input logic restart);
		for (int i = lo; i < hi; i++)
			queue_byte(pack_img[i], restart && i == lo);
	endtask

	// Hold until every queued byte is taken and every result has come back,
	// then let the pipeline drain.
	task automatic settle();
		@(negedge clk);
		while (image_q.size() != 0 || in_valid || deframed_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	// Write pak_size only once the block is idle.
	task automatic set_pak_size(input logic [31:0] v);
		settle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		pak_bound = v;
		@(negedge clk);
	endtask

	// One phase: pick a pack shape and a pak_size, then send it.
	task automatic queue_random_phase();
		int unsigned style;
		int unsigned entries;
		int unsigned klen;
		int unsigned dlen;
		int unsigned n;
		int unsigned n_send;
		int unsigned split;
		int unsigned idx;
		logic [31:0] bound;
		logic [31:0] key_word;
		logic [7:0]  flip;
		style = $urandom_range(0, 19);
		if (style >= 18) begin
			// noise: random bytes with restarts sprinkled in
			case ($urandom_range(0, 2))
				0: bound = $urandom_range(0, 16);
				1: bound = $urandom();
				default: bound = 32'hFFFF_FFFF;
			endcase
			set_pak_size(bound);
			n = $urandom_range(4, 40);
			repeat (n) queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
		end else begin
			entries = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
			start_header($urandom(), (style == 17) ? $urandom() : entries);
			for (int e = 0; e < entries; e++) begin
				klen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
				key_word = klen;
				// huge key length, often close enough to the 32-bit top to need 33 bits
				if (style == 16 && e == entries - 1)
					key_word = $urandom_range(0, 1) ? $urandom() :
						32'hFFFF_FFFF - $urandom_range(0, 60);
				add_word(key_word);
				repeat (klen) pack_img.push_back(8'($urandom_range(0, 255)));
				dlen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				add_word(dlen);
				repeat (dlen) pack_img.push_back(8'($urandom_range(0, 255)));
			end
			n = pack_img.size();
			case (style)
				8, 9: bound = n + $urandom_range(1, 16);
				10: bound = 32'hFFFF_FFFF;
				11, 12, 13: bound = n - $urandom_range(1, 8);
				14: begin
					idx = $urandom_range(0, 3);
					flip = 8'($urandom_range(1, 255));
					pack_img[idx] = pack_img[idx] ^ flip;
					bound = n;
				end
				15: bound = $urandom_range(0, 11);
				16, 17: bound = $urandom_range(0, 1) ? 32'hFFFF_FFFF : n;
				default: bound = n;
			endcase
			// trailing bytes past the end of the pack land as ignored
			repeat ($urandom_range(0, 3)) pack_img.push_back(8'($urandom_range(0, 255)));
			n_send = pack_img.size();
			// sometimes cut the pack short; the next phase restarts anyway
			if ($urandom_range(0, 9) == 0)
				n_send = $urandom_range(1, n_send - 1);
			set_pak_size(bound);
			if (n_send >= 2 && $urandom_range(0, 7) == 0) begin
				// change pak_size in the middle of a pack, then carry on
				split = $urandom_range(1, n_send - 1);
				queue_slice(0, split, 1'b1);
				set_pak_size($urandom_range(0, 1) ? bound + $urandom_range(0, 8) :
					bound - $urandom_range(0, 8));
				queue_slice(split, n_send, 1'b0);
			end else begin
				queue_slice(0, n_send, 1'b1);
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// Byte driver: hold the payload while stalled, advance on acceptance,
	// idle in random gaps between bursts.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : feed_bytes
		stim_t nxt;
		deframed_t pred;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				pred = deframe_byte(data_byte, first_byte);
				accepted_bytes++;
				deframed_q.push_back(pred);
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0 || image_q.size() == 0) begin
					if (gap_left != 0)
						gap_left--;
					in_valid <= 1'b0;
				end else begin
					nxt = image_q.pop_front();
					data_byte <= nxt.value;
					first_byte <= nxt.first;
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 :
							$urandom_range(1, ($urandom_range(0, 5) == 0) ? 20 : 4);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result stall: rotate a 16-bit pattern, reload it when stall_phase wraps.
	// Bit 15 of a random pattern stays clear so a stall never lasts forever.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		stall_phase <= stall_phase + 6'd1;
		if (stall_phase == 6'd63) begin
			case ($urandom_range(0, 3))
				0: stall_pat <= 16'h0000;
				1: stall_pat <= 16'h5555;
				default: stall_pat <= 16'($urandom_range(0, 16'h7FFF));
			endcase
		end else begin
			stall_pat <= {stall_pat[0], stall_pat[15:1]};
		end
		out_stall <= stall_pat[0];
	end

	// ---------------------------------------------------------------------
	// Result monitor: compare each accepted result with the oldest prediction.
	// ---------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatches < PRINT_CAP)
			$display("result %0d: %s is %0h, predicted %0h", results_seen, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_results
		deframed_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (deframed_q.size() == 0) begin
				report_mismatch("unpredicted result, byte", 32'(out_byte), 32'd0);
			end else begin
				want = deframed_q.pop_front();
				if (out_byte !== want.value)
					report_mismatch("out_byte", 32'(out_byte), 32'(want.value));
				if (byte_kind !== want.kind)
					report_mismatch("byte_kind", 32'(byte_kind), 32'(want.kind));
				if (entry_number !== want.entry)
					report_mismatch("entry_number", entry_number, want.entry);
				if (field_end !== want.fend)
					report_mismatch("field_end", 32'(field_end), 32'(want.fend));
				if (status !== want.status)
					report_mismatch("status", 32'(status), 32'(want.status));
			end
			results_seen++;
		end
	end

	// ---------------------------------------------------------------------
	// Watchdog: end the run if no transaction moves on either side for too long.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------------
	// Sequence: reset, directed cases, random phases, drain and verdict.
	// ---------------------------------------------------------------------
	initial begin : run
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Out of reset pak_size is 0 and the parser already sits at a pack start:
		// the first byte, with no restart, reports a short image, the next is ignored.
		queue_byte(8'h4E, 1'b0);
		queue_byte(8'hFF, 1'b0);

		// Smallest legal pack size: a bad magic on byte 1 first.
		set_pak_size(HDR_LEN);
		queue_byte(8'h4E, 1'b1);
		queue_byte(8'h00, 1'b0);

		// Zero entry count: done on the last header byte, then ignored bytes.
		start_header(32'hFFFF_FFFF, 32'd0);
		queue_slice(0, pack_img.size(), 1'b1);
		queue_byte(8'hA5, 1'b0);

		// Largest pack size with a single empty entry.
		set_pak_size(32'hFFFF_FFFF);
		start_header(32'd0, 32'd1);
		add_word(32'd0);
		add_word(32'd0);
		queue_slice(0, pack_img.size(), 1'b1);

		while (accepted_bytes < RANDOM_BYTES)
			queue_random_phase();

		// the last phase ends idle: nothing left to send or to receive
		settle();
		if (mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
